@@ hw/rtl/npdc_pkg.sv @@
package npdc_pkg;

    localparam int DEPTH_W    = 16;
    localparam int COLOUR_W   = 8;
    localparam int MODE_W     = 2;
    localparam int REST_IN_W  = 12;
    localparam int SCALED_W   = 11;

    localparam logic [DEPTH_W-1:0] DEPTH_SAT  = 16'd12800;
    localparam logic [DEPTH_W-1:0] BAND_STEP  = 16'd2560;
    localparam logic [7:0]         COLOUR_MAX = 8'd255;
    localparam logic [11:0]        RECIP_5    = 12'd3277;
    localparam int                 RECIP_SH   = 14;
    localparam int                 STEP_SH    = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_STORE = 2'd1,
        MODE_QUERY = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RAMP,
        ST_LOAD
    } t_state;

    typedef enum logic [2:0] {
        BAND_RED,
        BAND_YELLOW,
        BAND_GREEN,
        BAND_CYAN,
        BAND_BLUE,
        BAND_SAT
    } t_band;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic best_clr;
    } t_cell_ctl;

endpackage

@@ hw/rtl/npdc_cell.sv @@
module npdc_cell
    import npdc_pkg::*;
#(
    parameter int  BANK       = 1024,
    parameter int  COORD_BITS = 11,
    localparam int AW         = (BANK > 1) ? $clog2(BANK) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctl               i_ctl,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic [COORD_BITS-1:0]   i_wr_x,
    input  logic [COORD_BITS-1:0]   i_wr_y,
    input  logic [DEPTH_W-1:0]      i_wr_depth,
    input  logic [AW-1:0]           i_rd_addr,
    input  logic [COORD_BITS-1:0]   i_qx,
    input  logic [COORD_BITS-1:0]   i_qy,
    input  logic                    i_chain_found,
    input  logic [2*COORD_BITS:0]   i_chain_dist,
    input  logic [DEPTH_W-1:0]      i_chain_depth,
    output logic                    o_chain_found,
    output logic [2*COORD_BITS:0]   o_chain_dist,
    output logic [DEPTH_W-1:0]      o_chain_depth
);

    localparam int ENTRY_W = 2 * COORD_BITS + DEPTH_W;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int DIST_W  = 2 * COORD_BITS + 1;

    logic [ENTRY_W-1:0] mem [BANK];

    logic [ENTRY_W-1:0]    r_rd;
    logic                  r_v1;
    logic [SQ_W-1:0]       r_sq_x;
    logic [SQ_W-1:0]       r_sq_y;
    logic [DEPTH_W-1:0]    r_d2;
    logic                  r_v2;
    logic                  r_found;
    logic [DIST_W-1:0]     r_best_dist;
    logic [DEPTH_W-1:0]    r_best_depth;
    logic                  r_chain_found;
    logic [DIST_W-1:0]     r_chain_dist;
    logic [DEPTH_W-1:0]    r_chain_depth;

    logic [COORD_BITS-1:0] rd_x;
    logic [COORD_BITS-1:0] rd_y;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [DIST_W-1:0]     cand_dist;
    logic                  take_local;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= {i_wr_depth, i_wr_y, i_wr_x};
        end
        r_rd <= mem[i_rd_addr];
    end

    assign rd_x = r_rd[COORD_BITS-1:0];
    assign rd_y = r_rd[2*COORD_BITS-1:COORD_BITS];
    assign dx   = (rd_x >= i_qx) ? (rd_x - i_qx) : (i_qx - rd_x);
    assign dy   = (rd_y >= i_qy) ? (rd_y - i_qy) : (i_qy - rd_y);
    assign cand_dist = {1'b0, r_sq_x} + {1'b0, r_sq_y};

    always_ff @(posedge i_clk) begin
        r_sq_x <= dx * dx;
        r_sq_y <= dy * dy;
        r_d2   <= r_rd[ENTRY_W-1:2*COORD_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.rd_en;
            r_v2 <= r_v1;
        end
    end

    // Strict comparison keeps the earliest point on a tie.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.best_clr) begin
            r_found <= 1'b0;
        end else if (r_v2 && (!r_found || cand_dist < r_best_dist)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && (!r_found || cand_dist < r_best_dist)) begin
            r_best_dist  <= cand_dist;
            r_best_depth <= r_d2;
        end
    end

    // Points in earlier cells come first, so the incoming best wins a tie.
    assign take_local = r_found && (!i_chain_found || r_best_dist < i_chain_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_found <= 1'b0;
        end else begin
            r_chain_found <= i_chain_found || r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_local) begin
            r_chain_dist  <= r_best_dist;
            r_chain_depth <= r_best_depth;
        end else begin
            r_chain_dist  <= i_chain_dist;
            r_chain_depth <= i_chain_depth;
        end
    end

    assign o_chain_found = r_chain_found;
    assign o_chain_dist  = r_chain_dist;
    assign o_chain_depth = r_chain_depth;

endmodule

@@ hw/rtl/npdc_ramp.sv @@
module npdc_ramp
    import npdc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_found,
    input  logic [DEPTH_W-1:0]  i_depth,
    output logic                o_done,
    output logic [COLOUR_W-1:0] o_red,
    output logic [COLOUR_W-1:0] o_green,
    output logic [COLOUR_W-1:0] o_blue,
    output logic [DEPTH_W-1:0]  o_depth,
    output logic                o_empty
);

    logic                  r_v0;
    logic                  r_v1;
    logic                  r_v2;
    t_band                 r_band0;
    t_band                 r_band1;
    logic [REST_IN_W-1:0]  r_m;
    logic [SCALED_W-1:0]   r_t;
    logic [DEPTH_W-1:0]    r_dep0;
    logic [DEPTH_W-1:0]    r_dep1;
    logic                  r_empty0;
    logic                  r_empty1;
    logic [COLOUR_W-1:0]   r_red;
    logic [COLOUR_W-1:0]   r_green;
    logic [COLOUR_W-1:0]   r_blue;
    logic [DEPTH_W-1:0]    r_dep2;
    logic                  r_empty2;

    logic [DEPTH_W-1:0]    d;
    t_band                 band;
    logic [DEPTH_W-1:0]    base;
    logic [DEPTH_W-1:0]    m_full;
    logic [19:0]           t_prod;
    logic [22:0]           q_prod;
    logic [COLOUR_W-1:0]   rest;

    assign d = i_found ? i_depth : '0;

    always_comb begin
        if (d >= DEPTH_SAT) begin
            band = BAND_SAT;
            base = '0;
        end else if (d >= DEPTH_W'(BAND_STEP * 4)) begin
            band = BAND_BLUE;
            base = DEPTH_W'(BAND_STEP * 4);
        end else if (d >= DEPTH_W'(BAND_STEP * 3)) begin
            band = BAND_CYAN;
            base = DEPTH_W'(BAND_STEP * 3);
        end else if (d >= DEPTH_W'(BAND_STEP * 2)) begin
            band = BAND_GREEN;
            base = DEPTH_W'(BAND_STEP * 2);
        end else if (d >= BAND_STEP) begin
            band = BAND_YELLOW;
            base = BAND_STEP;
        end else begin
            band = BAND_RED;
            base = '0;
        end
        m_full = d - base;
    end

    assign t_prod = 20'(r_m) * 20'(COLOUR_MAX);
    assign q_prod = 23'(r_t) * 23'(RECIP_5);
    assign rest   = COLOUR_W'(q_prod >> RECIP_SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_band0  <= band;
            r_m      <= (band == BAND_SAT) ? '0 : m_full[REST_IN_W-1:0];
            r_dep0   <= d;
            r_empty0 <= !i_found;
        end
        if (r_v0) begin
            r_t      <= SCALED_W'(t_prod >> STEP_SH);
            r_band1  <= r_band0;
            r_dep1   <= r_dep0;
            r_empty1 <= r_empty0;
        end
        if (r_v1) begin
            r_dep2   <= r_dep1;
            r_empty2 <= r_empty1;
            unique case (r_band1)
                BAND_RED: begin
                    r_red <= COLOUR_MAX; r_green <= rest; r_blue <= '0;
                end
                BAND_YELLOW: begin
                    r_red <= COLOUR_MAX - rest; r_green <= COLOUR_MAX; r_blue <= '0;
                end
                BAND_GREEN: begin
                    r_red <= '0; r_green <= COLOUR_MAX; r_blue <= rest;
                end
                BAND_CYAN: begin
                    r_red <= '0; r_green <= COLOUR_MAX - rest; r_blue <= COLOUR_MAX;
                end
                BAND_BLUE: begin
                    r_red <= rest; r_green <= '0; r_blue <= COLOUR_MAX;
                end
                default: begin
                    r_red <= COLOUR_MAX; r_green <= '0; r_blue <= COLOUR_MAX;
                end
            endcase
        end
    end

    assign o_done  = r_v2;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_depth = r_dep2;
    assign o_empty = r_empty2;

endmodule

@@ hw/rtl/nearest_point_depth_colormap.sv @@
// Stores up to MAX_POINTS depth points and, for each query beat, returns the colour of the
// nearest stored point. Clear and store beats give no result beat.
// The table is split over NUM_CELLS cells, each scans its own memory bank at one entry per
// cycle through its single read port, and the best candidate is then passed along the row
// of cells, one cell per cycle, before the colour ramp. The next beat is taken in the cycle
// in which the result beat appears. A finished result waits in the output register while
// the next beat is taken in; a query that finishes while an earlier result still waits
// holds until that result is taken.
module nearest_point_depth_colormap
    import npdc_pkg::*;
#(
    parameter int  MAX_POINTS = 4096,
    parameter int  COORD_BITS = 11,
    parameter int  NUM_CELLS  = 4,
    localparam int IN_BITS    = 2 * COORD_BITS + DEPTH_W,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W      = 3 * COLOUR_W + DEPTH_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IN_W-1:0]     s_axis_tdata,   // pixel_x, pixel_y, depth, zero fill
    input  logic [MODE_W-1:0]   s_axis_tuser,   // mode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,   // red, green, blue, nearest_depth
    output logic [0:0]          m_axis_tuser    // table_empty
);

    localparam int BANK      = (MAX_POINTS + NUM_CELLS - 1) / NUM_CELLS;
    localparam int AW        = (BANK > 1) ? $clog2(BANK) : 1;
    localparam int CW        = $clog2(MAX_POINTS + 1);
    localparam int CIW       = $clog2(NUM_CELLS + 1);
    localparam int DIST_W    = 2 * COORD_BITS + 1;
    localparam int DRAIN_LEN = NUM_CELLS + 3;
    localparam int DRW       = $clog2(DRAIN_LEN + 1);

    t_state                r_state;
    t_state                n_state;
    logic [CW-1:0]         r_count;
    logic [CIW-1:0]        r_wr_cell;
    logic [AW-1:0]         r_wr_addr;
    logic [COORD_BITS-1:0] r_qx;
    logic [COORD_BITS-1:0] r_qy;
    logic [AW-1:0]         r_scan_addr;
    logic [DRW-1:0]        r_drain;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;
    logic                  r_out_empty;

    logic                  in_acc;
    t_mode                 mode;
    logic [COORD_BITS-1:0] in_x;
    logic [COORD_BITS-1:0] in_y;
    logic [DEPTH_W-1:0]    in_depth;
    logic                  do_store;
    logic                  do_clear;
    logic                  do_query;
    logic                  scan_last;
    logic                  drain_last;
    logic                  scan_en;
    logic                  ramp_start;
    logic                  load_out;

    logic                  chain_found [NUM_CELLS+1];
    logic [DIST_W-1:0]     chain_dist  [NUM_CELLS+1];
    logic [DEPTH_W-1:0]    chain_depth [NUM_CELLS+1];

    logic                  ramp_done;
    logic [COLOUR_W-1:0]   ramp_red;
    logic [COLOUR_W-1:0]   ramp_green;
    logic [COLOUR_W-1:0]   ramp_blue;
    logic [DEPTH_W-1:0]    ramp_depth;
    logic                  ramp_empty;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign mode     = t_mode'(s_axis_tuser);
    assign in_x     = s_axis_tdata[COORD_BITS-1:0];
    assign in_y     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_depth = s_axis_tdata[IN_BITS-1:2*COORD_BITS];

    always_comb begin
        do_store = 1'b0;
        do_clear = 1'b0;
        do_query = 1'b0;
        unique case (mode)
            MODE_CLEAR: do_clear = in_acc;
            MODE_STORE: do_store = in_acc && (r_count < CW'(MAX_POINTS));
            MODE_QUERY: do_query = in_acc;
            default:    ;
        endcase
    end

    assign scan_last  = (r_scan_addr == AW'(BANK - 1));
    assign drain_last = (r_drain == DRW'(DRAIN_LEN - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (do_query) n_state = ST_SCAN;
            ST_SCAN:  if (scan_last) n_state = ST_DRAIN;
            ST_DRAIN: if (drain_last) n_state = ST_RAMP;
            ST_RAMP:  if (ramp_done) n_state = ST_LOAD;
            ST_LOAD:  if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        scan_en       = 1'b0;
        ramp_start    = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_SCAN:  scan_en = 1'b1;
            ST_DRAIN: ramp_start = drain_last;
            ST_RAMP:  ;
            ST_LOAD:  load_out = !r_out_valid || m_axis_tready;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_wr_cell   <= '0;
            r_wr_addr   <= '0;
            r_scan_addr <= '0;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_clear) begin
                r_count   <= '0;
                r_wr_cell <= '0;
                r_wr_addr <= '0;
            end else if (do_store) begin
                r_count <= r_count + 1'b1;
                if (r_wr_addr == AW'(BANK - 1)) begin
                    r_wr_addr <= '0;
                    r_wr_cell <= r_wr_cell + 1'b1;
                end else begin
                    r_wr_addr <= r_wr_addr + 1'b1;
                end
            end
            if (scan_en) begin
                r_scan_addr <= scan_last ? '0 : r_scan_addr + 1'b1;
            end
            if (r_state == ST_DRAIN) begin
                r_drain <= drain_last ? '0 : r_drain + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_query) begin
            r_qx <= in_x;
            r_qy <= in_y;
        end
        if (load_out) begin
            r_out_data  <= {ramp_depth, ramp_blue, ramp_green, ramp_red};
            r_out_empty <= ramp_empty;
        end
    end

    assign chain_found[0] = 1'b0;
    assign chain_dist[0]  = '0;
    assign chain_depth[0] = '0;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        t_cell_ctl ctl;
        logic      entry_valid;

        assign entry_valid = (CIW'(k) < r_wr_cell) ||
                             ((CIW'(k) == r_wr_cell) && (r_scan_addr < r_wr_addr));
        assign ctl.wr_en    = do_store && (r_wr_cell == CIW'(k));
        assign ctl.rd_en    = scan_en && entry_valid;
        assign ctl.best_clr = do_query;

        npdc_cell #(
            .BANK       (BANK),
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_wr_addr     (r_wr_addr),
            .i_wr_x        (in_x),
            .i_wr_y        (in_y),
            .i_wr_depth    (in_depth),
            .i_rd_addr     (r_scan_addr),
            .i_qx          (r_qx),
            .i_qy          (r_qy),
            .i_chain_found (chain_found[k]),
            .i_chain_dist  (chain_dist[k]),
            .i_chain_depth (chain_depth[k]),
            .o_chain_found (chain_found[k+1]),
            .o_chain_dist  (chain_dist[k+1]),
            .o_chain_depth (chain_depth[k+1])
        );
    end

    npdc_ramp u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ramp_start),
        .i_found (chain_found[NUM_CELLS]),
        .i_depth (chain_depth[NUM_CELLS]),
        .o_done  (ramp_done),
        .o_red   (ramp_red),
        .o_green (ramp_green),
        .o_blue  (ramp_blue),
        .o_depth (ramp_depth),
        .o_empty (ramp_empty)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_empty;

endmodule
